### rtl/core/afa_pkg.sv
`default_nettype none

package afa_pkg;

  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgDataW = 64;

  localparam logic [2:0] REG_DEST    = 3'd0;
  localparam logic [2:0] REG_SOURCE  = 3'd1;
  localparam logic [2:0] REG_RELAY   = 3'd2;
  localparam logic [2:0] REG_SSID    = 3'd3;
  localparam logic [2:0] REG_CONTROL = 3'd4;
  localparam logic [2:0] REG_PID     = 3'd5;
  localparam logic [2:0] REG_FLAG    = 3'd6;
  localparam logic [2:0] REG_LENGTH  = 3'd7;

  localparam logic [47:0] DEST_RESET    = 48'h4351_2020_2020;
  localparam logic [47:0] SOURCE_RESET  = 48'h5655_3244_4D51;
  localparam logic [47:0] RELAY_RESET   = 48'h5245_4C41_5920;
  localparam logic [23:0] SSID_RESET    = 24'h60_68_61;
  localparam logic [7:0]  CONTROL_RESET = 8'h03;
  localparam logic [7:0]  PID_RESET     = 8'hF0;
  localparam logic [7:0]  FLAG_RESET    = 8'h7E;
  localparam logic [7:0]  LENGTH_RESET  = 8'd34;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [4:0] PH_FLAG       = 5'd0;
  localparam logic [4:0] PH_DEST0      = 5'd1;
  localparam logic [4:0] PH_DEST_SSID  = 5'd7;
  localparam logic [4:0] PH_SRC0       = 5'd8;
  localparam logic [4:0] PH_SRC_SSID   = 5'd14;
  localparam logic [4:0] PH_RELAY0     = 5'd15;
  localparam logic [4:0] PH_RELAY_SSID = 5'd21;
  localparam logic [4:0] PH_CONTROL    = 5'd22;
  localparam logic [4:0] PH_PID        = 5'd23;
  localparam logic [4:0] PH_PAYLOAD    = 5'd24;
  localparam logic [4:0] PH_CRC_LO     = 5'd25;
  localparam logic [4:0] PH_CRC_HI     = 5'd26;
  localparam logic [4:0] PH_CLOSE      = 5'd27;

  typedef struct packed {
    logic [47:0] dest;
    logic [47:0] source;
    logic [47:0] relay;
    logic [23:0] ssid;
    logic [7:0]  control;
    logic [7:0]  pid;
    logic [7:0]  flag;
    logic [7:0]  length;
  } afa_cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'd0, x[7:4]};
    return {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
  endfunction

  function automatic logic [7:0] call_char(input logic [47:0] call, input logic [2:0] k);
    return call[8 * (3'd5 - k) +: 8];
  endfunction

endpackage

`default_nettype wire

### rtl/core/afa_in_if.sv
`default_nettype none

interface afa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;

  modport source (output valid, output payload_byte, input ready);
  modport sink (input valid, input payload_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/afa_out_if.sv
`default_nettype none

interface afa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/core/afa_regs.sv
`default_nettype none

module afa_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [afa_pkg::CfgAddrW-1:0]   paddr,
  input  wire logic [afa_pkg::CfgDataW-1:0]   pwdata,
  output logic      [afa_pkg::CfgDataW-1:0]   prdata,
  output logic                                pready,
  output afa_pkg::afa_cfg_t                   cfg
);
  import afa_pkg::*;

  logic       wr_en;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[CfgAddrW-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest    <= DEST_RESET;
      cfg.source  <= SOURCE_RESET;
      cfg.relay   <= RELAY_RESET;
      cfg.ssid    <= SSID_RESET;
      cfg.control <= CONTROL_RESET;
      cfg.pid     <= PID_RESET;
      cfg.flag    <= FLAG_RESET;
      cfg.length  <= LENGTH_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DEST:    cfg.dest    <= pwdata[47:0];
        REG_SOURCE:  cfg.source  <= pwdata[47:0];
        REG_RELAY:   cfg.relay   <= pwdata[47:0];
        REG_SSID:    cfg.ssid    <= pwdata[23:0];
        REG_CONTROL: cfg.control <= pwdata[7:0];
        REG_PID:     cfg.pid     <= pwdata[7:0];
        REG_FLAG:    cfg.flag    <= pwdata[7:0];
        REG_LENGTH:  cfg.length  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_DEST:    prdata = {16'd0, cfg.dest};
      REG_SOURCE:  prdata = {16'd0, cfg.source};
      REG_RELAY:   prdata = {16'd0, cfg.relay};
      REG_SSID:    prdata = {40'd0, cfg.ssid};
      REG_CONTROL: prdata = {56'd0, cfg.control};
      REG_PID:     prdata = {56'd0, cfg.pid};
      REG_FLAG:    prdata = {56'd0, cfg.flag};
      REG_LENGTH:  prdata = {56'd0, cfg.length};
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/ax25_frame_assembler_unit.sv
// Throughput: while the output is drained and a payload byte is held, one frame byte per cycle
// leaves; a payload byte inside a frame is taken every cycle while the output is drained.
// A payload byte inside a frame passes from the holding register to the output register;
// a frame-opening byte follows 24 header bytes, and a closing byte is followed by 3 trailer
// bytes.
// Reset is synchronous and active high; it empties both registers, restores the CRC to
// 0xFFFF and loads the configuration registers with their default values.
`default_nettype none

module ax25_frame_assembler_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  afa_in_if.sink                             din,
  afa_out_if.source                          dout,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [afa_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [afa_pkg::CfgDataW-1:0]  pwdata,
  output logic      [afa_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready
);
  import afa_pkg::*;

  afa_cfg_t cfg;

  logic        hold_valid;
  logic        hold_valid_next;
  logic [7:0]  hold_byte;
  logic [4:0]  phase;
  logic [4:0]  phase_next;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  count;
  logic [7:0]  count_next;
  logic        frame_open;
  logic        frame_open_next;
  logic        out_valid;
  logic        out_valid_next;
  logic [7:0]  out_byte;
  logic        out_eof;

  logic        advance;
  logic        last;
  logic        in_ready;
  logic        in_take;
  logic [4:0]  eff;
  logic [7:0]  sel_byte;
  logic        sel_eof;
  logic        crc_upd;
  logic [7:0]  limit;

  afa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance = hold_valid && (!out_valid || dout.ready);
  assign eff     = (phase == PH_FLAG && frame_open) ? PH_PAYLOAD : phase;
  assign limit   = (cfg.length == 8'd0) ? 8'd1 : cfg.length;

  always_comb begin
    sel_eof = 1'b0;
    crc_upd = 1'b1;
    case (eff) inside
      PH_FLAG: begin
        sel_byte = cfg.flag;
        crc_upd  = 1'b0;
      end
      [PH_DEST0:PH_DEST_SSID-5'd1]:   sel_byte = call_char(cfg.dest, 3'(eff - PH_DEST0));
      PH_DEST_SSID:                   sel_byte = cfg.ssid[23:16];
      [PH_SRC0:PH_SRC_SSID-5'd1]:     sel_byte = call_char(cfg.source, 3'(eff - PH_SRC0));
      PH_SRC_SSID:                    sel_byte = cfg.ssid[15:8];
      [PH_RELAY0:PH_RELAY_SSID-5'd1]: sel_byte = call_char(cfg.relay, 3'(eff - PH_RELAY0));
      PH_RELAY_SSID:                  sel_byte = cfg.ssid[7:0];
      PH_CONTROL:                     sel_byte = cfg.control;
      PH_PID:                         sel_byte = cfg.pid;
      PH_PAYLOAD:                     sel_byte = hold_byte;
      PH_CRC_LO: begin
        sel_byte = crc[7:0];
        crc_upd  = 1'b0;
      end
      PH_CRC_HI: begin
        sel_byte = crc[15:8];
        crc_upd  = 1'b0;
      end
      PH_CLOSE: begin
        sel_byte = cfg.flag;
        sel_eof  = 1'b1;
        crc_upd  = 1'b0;
      end
      default: begin
        sel_byte = cfg.flag;
        crc_upd  = 1'b0;
      end
    endcase
  end

  always_comb begin
    last            = 1'b0;
    phase_next      = phase;
    crc_next        = crc;
    count_next      = count;
    frame_open_next = frame_open;
    if (advance) begin
      phase_next = eff + 5'd1;
      if (crc_upd) begin
        crc_next = crc_byte(crc, sel_byte);
      end
      if (eff == PH_FLAG) begin
        frame_open_next = 1'b1;
      end
      if (eff == PH_PAYLOAD) begin
        count_next = count + 8'd1;
        if (count_next < limit) begin
          phase_next = PH_FLAG;
          last       = 1'b1;
        end
      end
      if (eff == PH_CLOSE) begin
        phase_next      = PH_FLAG;
        crc_next        = CRC_INIT;
        count_next      = 8'd0;
        frame_open_next = 1'b0;
        last            = 1'b1;
      end
    end
  end

  assign in_ready        = !hold_valid || (advance && last);
  assign in_take         = din.valid && in_ready;
  assign hold_valid_next = in_take ? 1'b1 : ((advance && last) ? 1'b0 : hold_valid);
  assign out_valid_next  = advance ? 1'b1 : (out_valid && !dout.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      phase      <= PH_FLAG;
      crc        <= CRC_INIT;
      count      <= 8'd0;
      frame_open <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
      phase      <= phase_next;
      crc        <= crc_next;
      count      <= count_next;
      frame_open <= frame_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_byte <= din.payload_byte;
    end
    if (advance) begin
      out_byte <= sel_byte;
      out_eof  <= sel_eof;
    end
  end

  assign din.ready         = in_ready;
  assign dout.valid        = out_valid;
  assign dout.frame_byte   = out_byte;
  assign dout.end_of_frame = out_eof;

endmodule

`default_nettype wire

### rtl/core/afa_checker.sv
`default_nettype none

module afa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] frame_byte,
  input wire logic       end_of_frame
);

  // A stalled result keeps its place in the output register.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped during a stall");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(frame_byte) && $stable(end_of_frame))
    else $error("output payload changed during a stall");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A byte just taken sits in the holding register, so a stalled output blocks the input.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while the holding register is full");

endmodule

bind ax25_frame_assembler_unit afa_checker u_afa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (din.valid),
  .in_ready     (din.ready),
  .out_valid    (dout.valid),
  .out_ready    (dout.ready),
  .frame_byte   (dout.frame_byte),
  .end_of_frame (dout.end_of_frame)
);

`default_nettype wire

### verif/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import afa_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned EndWait = 40;
  localparam int unsigned RandomItems = 60;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } frame_out_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  afa_in_if din_if ();
  afa_out_if dout_if ();

  ax25_frame_assembler_unit dut (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  afa_cfg_t    cfg;
  logic [15:0] frame_crc;
  logic [7:0]  frame_count;
  logic        frame_open;
  frame_out_t  frame_bytes_due[$];

  int errors = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int rx_hold = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  function automatic void due(input logic [7:0] b, input logic eof);
    frame_out_t e;
    e.frame_byte = b;
    e.end_of_frame = eof;
    frame_bytes_due.push_back(e);
  endfunction

  function automatic void due_crc(input logic [7:0] b);
    frame_crc = crc_update(frame_crc, b);
    due(b, 1'b0);
  endfunction

  function automatic void due_call(input logic [47:0] call, input logic [7:0] ssid);
    for (int k = 0; k < 6; k++) begin
      due_crc(call[47 - 8 * k -: 8]);
    end
    due_crc(ssid);
  endfunction

  function automatic void assemble_frame_bytes(input logic [7:0] b);
    logic [7:0] limit;
    limit = (cfg.length == 8'd0) ? 8'd1 : cfg.length;
    if (!frame_open) begin
      frame_crc = CRC_INIT;
      frame_count = 8'd0;
      due(cfg.flag, 1'b0);
      due_call(cfg.dest, cfg.ssid[23:16]);
      due_call(cfg.source, cfg.ssid[15:8]);
      due_call(cfg.relay, cfg.ssid[7:0]);
      due_crc(cfg.control);
      due_crc(cfg.pid);
      frame_open = 1'b1;
    end
    due_crc(b);
    frame_count = frame_count + 8'd1;
    if (frame_count >= limit) begin
      due(frame_crc[7:0], 1'b0);
      due(frame_crc[15:8], 1'b0);
      due(cfg.flag, 1'b1);
      frame_crc = CRC_INIT;
      frame_count = 8'd0;
      frame_open = 1'b0;
    end
  endfunction

  function automatic logic [63:0] reg_shadow(input logic [2:0] idx);
    case (idx)
      REG_DEST:    return {16'h0, cfg.dest};
      REG_SOURCE:  return {16'h0, cfg.source};
      REG_RELAY:   return {16'h0, cfg.relay};
      REG_SSID:    return {40'h0, cfg.ssid};
      REG_CONTROL: return {56'h0, cfg.control};
      REG_PID:     return {56'h0, cfg.pid};
      REG_FLAG:    return {56'h0, cfg.flag};
      default:     return {56'h0, cfg.length};
    endcase
  endfunction

  function automatic logic [63:0] random_reg_value(input logic [2:0] idx);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (idx)
      REG_DEST, REG_SOURCE, REG_RELAY: begin
        case ($urandom_range(3))
          0: v = 64'h0;
          1: v = {16'h0, {48{1'b1}}};
          default: v = {16'h0, v[47:0]};
        endcase
      end
      REG_SSID: v = {40'h0, v[23:0]};
      REG_LENGTH: v = 64'($urandom_range(0, 8));
      default: v = {56'h0, v[7:0]};
    endcase
    return v;
  endfunction

  task automatic cfg_check(input logic [2:0] idx);
    logic [63:0] got;
    logic [63:0] mask;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 3'b000};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (idx <= REG_RELAY) mask = {16'h0, {48{1'b1}}};
    else if (idx == REG_SSID) mask = {40'h0, {24{1'b1}}};
    else mask = {56'h0, 8'hFF};
    if ((got & mask) != reg_shadow(idx)) begin
      errors++;
      $display("%0t: register %0d read expected %h actual %h", $time, idx,
               reg_shadow(idx), got & mask);
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DEST:    cfg.dest = value[47:0];
      REG_SOURCE:  cfg.source = value[47:0];
      REG_RELAY:   cfg.relay = value[47:0];
      REG_SSID:    cfg.ssid = value[23:0];
      REG_CONTROL: cfg.control = value[7:0];
      REG_PID:     cfg.pid = value[7:0];
      REG_FLAG:    cfg.flag = value[7:0];
      default:     cfg.length = value[7:0];
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    cfg_check(idx);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(99) < 8) begin
      din_if.valid = 1'b0;
      @(negedge clk);
    end
    din_if.valid = 1'b1;
    din_if.payload_byte = b;
    do @(posedge clk); while (!din_if.ready);
    assemble_frame_bytes(b);
    items_sent++;
    @(negedge clk);
    din_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      dout_if.ready = 1'b0;
      rx_hold--;
    end else begin
      dout_if.ready = quiet || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (frame_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame byte %02h end_of_frame %b", $time,
                 dout_if.frame_byte, dout_if.end_of_frame);
      end else begin
        want = frame_bytes_due.pop_front();
        bytes_checked++;
        if (dout_if.end_of_frame) frames_closed++;
        if (dout_if.frame_byte !== want.frame_byte) begin
          errors++;
          if (errors < 100) begin
            $display("%0t: frame_byte expected %02h actual %02h", $time,
                     want.frame_byte, dout_if.frame_byte);
          end
        end
        if (dout_if.end_of_frame !== want.end_of_frame) begin
          errors++;
          if (errors < 100) begin
            $display("%0t: end_of_frame expected %b actual %b", $time,
                     want.end_of_frame, dout_if.end_of_frame);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic test_register_defaults();
    logic [2:0] r;
    r = REG_DEST;
    repeat (8) begin
      cfg_check(r);
      r = r + 3'd1;
    end
  endtask

  task automatic test_default_header_short_frame();
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drained();
    cfg_write(REG_LENGTH, 64'd1);
    send_byte(8'h80);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    cfg_write(REG_DEST, {16'h0, {48{1'b1}}});
    cfg_write(REG_SOURCE, {16'h0, {48{1'b1}}});
    cfg_write(REG_RELAY, {16'h0, {48{1'b1}}});
    cfg_write(REG_SSID, 64'hFF_FFFF);
    cfg_write(REG_CONTROL, 64'hFF);
    cfg_write(REG_PID, 64'hFF);
    cfg_write(REG_FLAG, 64'hFF);
    cfg_write(REG_LENGTH, 64'd0);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained();
    cfg_write(REG_DEST, 64'h0);
    cfg_write(REG_SOURCE, 64'h0);
    cfg_write(REG_RELAY, 64'h0);
    cfg_write(REG_SSID, 64'h0);
    cfg_write(REG_CONTROL, 64'h0);
    cfg_write(REG_PID, 64'h0);
    cfg_write(REG_FLAG, 64'h0);
    cfg_write(REG_LENGTH, 64'd1);
    send_byte(8'h55);
    send_byte(8'hAA);
    wait_drained();
  endtask

  task automatic test_header_write_mid_frame();
    cfg_write(REG_FLAG, 64'h7E);
    cfg_write(REG_LENGTH, 64'd4);
    send_byte(8'h01);
    send_byte(8'h02);
    wait_drained();
    cfg_write(REG_DEST, 64'h4142_4344_4546);
    cfg_write(REG_SSID, 64'h12_3456);
    cfg_write(REG_FLAG, 64'hC3);
    send_byte(8'h03);
    send_byte(8'h04);
    repeat (4) send_byte(8'($urandom));
    wait_drained();
  endtask

  task automatic test_output_stall();
    cfg_write(REG_LENGTH, 64'd12);
    quiet = 1'b1;
    rx_hold = 300;
    repeat (12) send_byte(8'($urandom));
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_long_frame();
    cfg_write(REG_LENGTH, 64'd255);
    repeat (6) send_byte(8'($urandom));
    wait_drained();
    cfg_write(REG_LENGTH, 64'd4);
    send_byte(8'($urandom));
    wait_drained();
  endtask

  task automatic test_random_frames();
    int stop_at;
    int r;
    int n;
    logic [2:0] idx;
    stop_at = items_sent + RandomItems;
    while (items_sent < stop_at) begin
      repeat ($urandom_range(0, 2)) begin
        idx = 3'($urandom_range(7));
        cfg_write(idx, random_reg_value(idx));
      end
      r = $urandom_range(99);
      if (r < 5) n = 0;
      else if (r < 80) n = $urandom_range(1, 6);
      else if (r < 95) n = $urandom_range(7, 20);
      else n = $urandom_range(21, 40);
      cfg_write(REG_LENGTH, 64'(n));
      quiet = ($urandom_range(9) == 0);
      if (n == 0) n = 1;
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(19) == 0) begin
          wait_drained();
          idx = 3'($urandom_range(7));
          cfg_write(idx, random_reg_value(idx));
        end
        send_byte(8'($urandom));
      end
      wait_drained();
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    din_if.valid = 1'b0;
    din_if.payload_byte = 8'h00;
    dout_if.ready = 1'b0;
    cfg.dest = DEST_RESET;
    cfg.source = SOURCE_RESET;
    cfg.relay = RELAY_RESET;
    cfg.ssid = SSID_RESET;
    cfg.control = CONTROL_RESET;
    cfg.pid = PID_RESET;
    cfg.flag = FLAG_RESET;
    cfg.length = LENGTH_RESET;
    frame_crc = CRC_INIT;
    frame_count = 8'd0;
    frame_open = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_defaults();
    test_default_header_short_frame();
    test_register_extremes();
    test_header_write_mid_frame();
    test_output_stall();
    test_long_frame();
    test_random_frames();

    wait_drained();
    repeat (EndWait) @(posedge clk);
    $display("Sent %0d payload bytes; checked %0d frame bytes in %0d closed frames.",
             items_sent, bytes_checked, frames_closed);
    $display("Covered register extremes, mid-frame writes, a length of 255 cut short and stalls.");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/core/afa_pkg.sv
rtl/core/afa_in_if.sv
rtl/core/afa_out_if.sv
rtl/core/afa_regs.sv
rtl/core/ax25_frame_assembler_unit.sv
rtl/core/afa_checker.sv
verif/testbench.sv
